// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the RTL of the note sequencer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that prop holds at every rising edge outside of reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that cons holds in the same cycle whenever ante holds, outside of reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/arpseq_pkg.sv =====
// ----------------------------------------------------------------------------
// arpseq_pkg
// Types, constants and table functions of the scale and arpeggio sequencer.
// ----------------------------------------------------------------------------
package arpseq_pkg;

  // Largest octave span that a run may cover.
  localparam int MAX_OCTAVES = 4;

  localparam int TOP_PITCH = 127;
  localparam int SEMIS     = 12;
  localparam int SEVEN     = 7;
  localparam int MAX_LEN   = 12;

  // Field widths fixed by the interface.
  localparam int PITCH_W  = 7;
  localparam int FINGER_W = 3;
  localparam int NOTE_W   = 7;
  localparam int TYPE_W   = 3;
  localparam int OCTCFG_W = 3;
  localparam int LEN_W    = 4;
  localparam int DEG_W    = 4;
  localparam int IVL_W    = 4;

  // Widths that follow from the octave span.
  localparam int IDX_W = $clog2(MAX_LEN * MAX_OCTAVES + 1);
  localparam int POS_W = $clog2(2 * MAX_LEN * MAX_OCTAVES + 1);
  localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
  localparam int SUM_W = $clog2(TOP_PITCH + SEMIS * MAX_OCTAVES + MAX_LEN);

  // Register port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_ROOT    = 3'd0,
    REG_ARP     = 3'd1,
    REG_TYPE    = 3'd2,
    REG_OCTAVES = 3'd3,
    REG_LEFT    = 3'd4,
    REG_DESCEND = 3'd5
  } reg_idx_t;

  // Register reset values.
  localparam logic [PITCH_W-1:0]  RST_ROOT    = 7'd60;
  localparam logic                RST_ARP     = 1'b0;
  localparam logic [TYPE_W-1:0]   RST_TYPE    = 3'd0;
  localparam logic [OCTCFG_W-1:0] RST_OCTAVES = 3'd1;
  localparam logic                RST_LEFT    = 1'b0;
  localparam logic                RST_DESCEND = 1'b1;

  // Finger given to the top tonic.
  localparam logic [FINGER_W-1:0] FINGER_TOP_LEFT  = 3'd1;
  localparam logic [FINGER_W-1:0] FINGER_TOP_RIGHT = 3'd5;
  localparam logic [FINGER_W-1:0] FINGER_NONE      = 3'd0;

  // Interval tables in semitones above the tonic.
  localparam logic [IVL_W-1:0] SCALE_TAB [8][MAX_LEN] = '{
    '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11},
    '{4'd0, 4'd2, 4'd4, 4'd7, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd3, 4'd5, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd3, 4'd5, 4'd6, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
  };

  // Arpeggio types six and seven repeat the major arpeggio.
  localparam logic [IVL_W-1:0] ARP_TAB [8][4] = '{
    '{4'd0, 4'd4, 4'd7, 4'd0},
    '{4'd0, 4'd3, 4'd7, 4'd0},
    '{4'd0, 4'd4, 4'd7, 4'd10},
    '{4'd0, 4'd4, 4'd7, 4'd11},
    '{4'd0, 4'd3, 4'd7, 4'd10},
    '{4'd0, 4'd3, 4'd6, 4'd0},
    '{4'd0, 4'd4, 4'd7, 4'd0},
    '{4'd0, 4'd4, 4'd7, 4'd0}
  };

  localparam logic [LEN_W-1:0] SCALE_LEN [8] = '{
    4'd7, 4'd7, 4'd7, 4'd7, 4'd12, 4'd5, 4'd5, 4'd6
  };
  localparam logic [LEN_W-1:0] ARP_LEN [8] = '{
    4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd3, 4'd3, 4'd3
  };

  // Hand patterns for seven-note scales; the eighth entry is never selected.
  localparam logic [FINGER_W-1:0] RIGHT_FINGERS [8] = '{
    3'd1, 3'd2, 3'd3, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0
  };
  localparam logic [FINGER_W-1:0] LEFT_FINGERS [8] = '{
    3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd3, 3'd2, 3'd0
  };

  // Settings and run geometry derived from the registers.
  typedef struct packed {
    logic [PITCH_W-1:0]                   root;
    logic                                 arp;
    logic [TYPE_W-1:0]                    ptype;
    logic                                 left;
    logic                                 finger_en;
    logic [IDX_W-1:0]                     asc_m1;
    logic [POS_W-1:0]                     top2;
    logic [POS_W-1:0]                     total_m1;
    logic [MAX_OCTAVES:0][IDX_W-1:0]      mul;
  } cfg_t;

  function automatic logic [LEN_W-1:0] pattern_len(input logic arp,
                                                   input logic [TYPE_W-1:0] ptype);
    pattern_len = arp ? ARP_LEN[ptype] : SCALE_LEN[ptype];
  endfunction

  function automatic logic [IVL_W-1:0] interval(input logic arp,
                                                input logic [TYPE_W-1:0] ptype,
                                                input logic [DEG_W-1:0] deg);
    interval = arp ? ARP_TAB[ptype][deg[1:0]] : SCALE_TAB[ptype][deg];
  endfunction

  function automatic logic [FINGER_W-1:0] finger_of(input logic left,
                                                    input logic [2:0] deg);
    finger_of = left ? LEFT_FINGERS[deg] : RIGHT_FINGERS[deg];
  endfunction

  // Octave count writes are held to the range 1 to MAX_OCTAVES.
  function automatic logic [OCTCFG_W-1:0] clamp_oct(input logic [OCTCFG_W-1:0] v);
    logic [OCTCFG_W-1:0] o;
    o = v;
    if (o == '0) begin
      o = OCTCFG_W'(1);
    end
    if (int'(o) > MAX_OCTAVES) begin
      o = OCTCFG_W'(MAX_OCTAVES);
    end
    clamp_oct = o;
  endfunction

endpackage

// ===== src/arpseq_cfg.sv =====
// ----------------------------------------------------------------------------
// arpseq_cfg
// Register file of the sequencer with its bus port, and the run geometry
// worked out from the register values at the edge that writes them.
// ----------------------------------------------------------------------------
module arpseq_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [arpseq_pkg::ADDR_W-1:0] paddr,
  input  logic [arpseq_pkg::DATA_W-1:0] pwdata,
  output logic [arpseq_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  output arpseq_pkg::cfg_t              cfg
);
  import arpseq_pkg::*;

  logic [PITCH_W-1:0]  root_pitch, root_pitch_next;
  logic                arpeggio_mode, arpeggio_mode_next;
  logic [TYPE_W-1:0]   pattern_type, pattern_type_next;
  logic [OCTCFG_W-1:0] octave_count, octave_count_next;
  logic                left_hand, left_hand_next;
  logic                descend_enable, descend_enable_next;
  logic                wr;
  reg_idx_t            idx;

  // Geometry of a run for one set of register values.
  function automatic cfg_t derive(input logic [PITCH_W-1:0] root, input logic arp,
                                  input logic [TYPE_W-1:0] ptype,
                                  input logic [OCTCFG_W-1:0] oct, input logic left,
                                  input logic desc);
    cfg_t             c;
    logic [LEN_W-1:0] len;
    len         = pattern_len(arp, ptype);
    c.root      = root;
    c.arp       = arp;
    c.ptype     = ptype;
    c.left      = left;
    c.finger_en = !arp && (int'(len) == SEVEN);
    c.asc_m1    = IDX_W'(int'(len) * int'(oct));
    c.top2      = POS_W'(POS_W'(c.asc_m1) << 1);
    c.total_m1  = desc ? c.top2 : POS_W'(c.asc_m1);
    for (int k = 0; k <= MAX_OCTAVES; k++) begin
      c.mul[k] = IDX_W'(int'(len) * k);
    end
    derive = c;
  endfunction

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);

  // Register write decode.
  always_comb begin
    root_pitch_next     = root_pitch;
    arpeggio_mode_next  = arpeggio_mode;
    pattern_type_next   = pattern_type;
    octave_count_next   = octave_count;
    left_hand_next      = left_hand;
    descend_enable_next = descend_enable;
    if (wr) begin
      case (idx)
        REG_ROOT:    root_pitch_next     = pwdata[PITCH_W-1:0];
        REG_ARP:     arpeggio_mode_next  = pwdata[0];
        REG_TYPE:    pattern_type_next   = pwdata[TYPE_W-1:0];
        REG_OCTAVES: octave_count_next   = clamp_oct(pwdata[OCTCFG_W-1:0]);
        REG_LEFT:    left_hand_next      = pwdata[0];
        REG_DESCEND: descend_enable_next = pwdata[0];
        default:     ;
      endcase
    end
  end

  // Registers and derived geometry update at the same edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      root_pitch     <= RST_ROOT;
      arpeggio_mode  <= RST_ARP;
      pattern_type   <= RST_TYPE;
      octave_count   <= RST_OCTAVES;
      left_hand      <= RST_LEFT;
      descend_enable <= RST_DESCEND;
      cfg            <= derive(RST_ROOT, RST_ARP, RST_TYPE, RST_OCTAVES, RST_LEFT,
                               RST_DESCEND);
    end else begin
      root_pitch     <= root_pitch_next;
      arpeggio_mode  <= arpeggio_mode_next;
      pattern_type   <= pattern_type_next;
      octave_count   <= octave_count_next;
      left_hand      <= left_hand_next;
      descend_enable <= descend_enable_next;
      cfg            <= derive(root_pitch_next, arpeggio_mode_next, pattern_type_next,
                               octave_count_next, left_hand_next, descend_enable_next);
    end
  end

  // Read back.
  always_comb begin
    case (idx)
      REG_ROOT:    prdata = DATA_W'(root_pitch);
      REG_ARP:     prdata = DATA_W'(arpeggio_mode);
      REG_TYPE:    prdata = DATA_W'(pattern_type);
      REG_OCTAVES: prdata = DATA_W'(octave_count);
      REG_LEFT:    prdata = DATA_W'(left_hand);
      REG_DESCEND: prdata = DATA_W'(descend_enable);
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== src/scale_arpeggio_note_sequencer.sv =====
// ----------------------------------------------------------------------------
// scale_arpeggio_note_sequencer
// Tick-driven scale and arpeggio player that gives one note per tick.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on the input channel (in_valid, in_stall, restart) is one tick and
// produces exactly one beat on the output channel (out_valid, out_stall,
// pitch, finger, note_index, last_note). A tick with restart set starts a new
// run; otherwise the run continues from where the last tick left it, and the
// tick after a beat marked last_note starts over at note 0.
// The tick is held in an input register, the note is worked out in one pass
// of combinational logic and stored in the output register, where it is
// shown until the receiver takes it. One tick per cycle is taken as long as
// the receiver keeps out_stall low.
// While out_stall holds a note, one more tick can wait in the input register;
// after that in_stall rises until the output register drains.
// The settings live on the APB port and take effect for the next tick; they
// are to be written while no tick is in flight, which the user must keep to;
// the block itself does not enforce it. Reset empties both registers,
// restores the settings to their reset values and puts the run back at note 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scale_arpeggio_note_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            restart,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [arpseq_pkg::PITCH_W-1:0]  pitch,
  output logic [arpseq_pkg::FINGER_W-1:0] finger,
  output logic [arpseq_pkg::NOTE_W-1:0]   note_index,
  output logic                            last_note,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [arpseq_pkg::ADDR_W-1:0]   paddr,
  input  logic [arpseq_pkg::DATA_W-1:0]   pwdata,
  output logic [arpseq_pkg::DATA_W-1:0]   prdata,
  output logic                            pready
);
  import arpseq_pkg::*;

  cfg_t                cfg;
  logic                a_valid;
  logic                a_restart;
  logic                b_ready;
  logic                move;
  logic [POS_W-1:0]    run_position, run_position_next;
  logic [POS_W-1:0]    pos;
  logic                falling;
  logic [POS_W-1:0]    idx_wide;
  logic [IDX_W-1:0]    idx;
  logic [OCT_W-1:0]    oct;
  logic [DEG_W-1:0]    deg;
  logic [SUM_W-1:0]    sum;
  logic [PITCH_W-1:0]  pitch_next;
  logic [FINGER_W-1:0] finger_next;
  logic                last_next;

  arpseq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: the output register takes a note when empty or being drained.
  assign b_ready  = !out_valid || !out_stall;
  assign move     = a_valid && b_ready;
  assign in_stall = a_valid && !b_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      a_valid <= 1'b1;
    end else if (move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_restart <= restart;
    end
  end

  // Position in the run; a stale position past the end starts a new run.
  always_comb begin
    pos = run_position;
    if (a_restart || (run_position > cfg.total_m1)) begin
      pos = '0;
    end
    falling  = pos > POS_W'(cfg.asc_m1);
    idx_wide = falling ? (cfg.top2 - pos) : pos;
    idx      = IDX_W'(idx_wide);
  end

  // Octave and degree: compare against each multiple of the pattern length.
  always_comb begin
    oct = '0;
    for (int k = 1; k <= MAX_OCTAVES; k++) begin
      oct = oct + OCT_W'(idx >= cfg.mul[k]);
    end
    deg = DEG_W'(idx - cfg.mul[oct]);
  end

  // Pitch with clamp at the top of the MIDI range.
  always_comb begin
    sum = SUM_W'(cfg.root) + SUM_W'(oct) * SUM_W'(SEMIS)
        + SUM_W'(interval(cfg.arp, cfg.ptype, deg));
    if (sum > SUM_W'(TOP_PITCH)) begin
      pitch_next = PITCH_W'(TOP_PITCH);
    end else begin
      pitch_next = PITCH_W'(sum);
    end
  end

  // Fingering applies to seven-note scales only; the top tonic has its own.
  always_comb begin
    if (!cfg.finger_en) begin
      finger_next = FINGER_NONE;
    end else if (pos == POS_W'(cfg.asc_m1)) begin
      finger_next = cfg.left ? FINGER_TOP_LEFT : FINGER_TOP_RIGHT;
    end else begin
      finger_next = finger_of(cfg.left, deg[2:0]);
    end
  end

  assign last_next         = (pos == cfg.total_m1);
  assign run_position_next = last_next ? '0 : (pos + POS_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      run_position <= '0;
    end else if (move) begin
      run_position <= run_position_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      pitch      <= pitch_next;
      finger     <= finger_next;
      note_index <= NOTE_W'(pos);
      last_note  <= last_next;
    end
  end

  // A held last note means the run has wrapped back to the start.
  `ASSERT_IMPLIES(a_last_wraps, clk, rst, out_valid && last_note, run_position == '0,
                  "run position did not wrap after the last note")
  // A held note that is not the last is followed by the next position.
  `ASSERT_IMPLIES(a_pos_follows, clk, rst, out_valid && !last_note,
                  NOTE_W'(run_position - POS_W'(1)) == note_index,
                  "run position does not follow the shown note")
  // Fingers appear only when the settings select a seven-note scale.
  `ASSERT_IMPLIES(a_finger_scale, clk, rst, out_valid && (finger != FINGER_NONE),
                  cfg.finger_en, "finger given for a pattern without fingering")

endmodule
